FILE: rtl/right_hand_wall_follower_core_macros.svh
// ----------------------------------------------------------------------------
// Assertion macros for the wall follower core
// Each macro checks an implication on the rising clock edge, held off in reset.
// ----------------------------------------------------------------------------
`ifndef RIGHT_HAND_WALL_FOLLOWER_CORE_MACROS_SVH
`define RIGHT_HAND_WALL_FOLLOWER_CORE_MACROS_SVH

// Same-cycle implication.
`define RHWF_CHECK(lbl, ante, cons, msg) \
   lbl: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error(msg);

// Next-cycle implication.
`define RHWF_CHECK_NEXT(lbl, ante, cons, msg) \
   lbl: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error(msg);

`endif

FILE: rtl/rhwf_pkg.sv
// ----------------------------------------------------------------------------
// rhwf_pkg
// Cell codes, headings, modes and the controller/datapath interface types.
// ----------------------------------------------------------------------------
`default_nettype none

package rhwf_pkg;

   typedef logic [2:0] code_type;
   typedef logic [1:0] dir_type;
   typedef logic [1:0] mode_type;
   typedef logic [1:0] addr_sel_type;

   localparam code_type CODE_OPEN    = 3'd0;
   localparam code_type CODE_WALL    = 3'd1;
   localparam code_type CODE_END     = 3'd2;
   localparam code_type CODE_DOT     = 3'd3;
   localparam code_type CODE_SMALL_O = 3'd4;
   localparam code_type CODE_BIG_O   = 3'd5;
   localparam code_type CODE_AT      = 3'd6;

   localparam dir_type DIR_NORTH = 2'd0;
   localparam dir_type DIR_EAST  = 2'd1;
   localparam dir_type DIR_SOUTH = 2'd2;
   localparam dir_type DIR_WEST  = 2'd3;

   localparam mode_type MODE_WRITE   = 2'd0;
   localparam mode_type MODE_STEP    = 2'd1;
   localparam mode_type MODE_READ    = 2'd2;
   localparam mode_type MODE_RESTART = 2'd3;

   // grid port address source
   localparam addr_sel_type SEL_RUNNER = 2'd0;
   localparam addr_sel_type SEL_CELL   = 2'd1;
   localparam addr_sel_type SEL_NEIGH  = 2'd2;

   typedef struct packed {
      logic         load_req;
      logic         rd_en;
      addr_sel_type sel;
      dir_type      dir;
      logic         wr_cell;
      logic         wr_crumb;
      logic         set_dir;
      logic         restart;
      logic         cap_here;
      logic         cap_shown;
      logic         out_load;
   } cmd_type;

   typedef struct packed {
      logic     code_wall;
      logic     code_end;
      dir_type  heading;
      mode_type mode;
   } sts_type;

   function automatic code_type next_crumb(input code_type code);
      code_type result;
      unique case (code)
         CODE_OPEN:    result = CODE_DOT;
         CODE_DOT:     result = CODE_SMALL_O;
         CODE_SMALL_O: result = CODE_BIG_O;
         CODE_END:     result = CODE_END;
         default:      result = CODE_AT;
      endcase
      return result;
   endfunction

endpackage

`default_nettype wire

FILE: rtl/rhwf_csr.sv
// ----------------------------------------------------------------------------
// rhwf_csr
// APB-style register file holding the runner's start column and row.
// ----------------------------------------------------------------------------
`default_nettype none

module rhwf_csr (
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire logic        psel,
   input  wire logic        penable,
   input  wire logic        pwrite,
   input  wire logic [2:0]  paddr,
   input  wire logic [31:0] pwdata,
   output logic [31:0]      prdata,
   output logic             pready,
   output logic [5:0]       start_x,
   output logic [5:0]       start_y
);

   localparam logic REG_START_X = 1'b0;
   localparam logic REG_START_Y = 1'b1;

   logic [5:0] start_x_ff, start_x_in;
   logic [5:0] start_y_ff, start_y_in;
   logic       wr_beat;

   assign pready  = 1'b1;
   assign wr_beat = psel && penable && pwrite;

   always_comb begin
      start_x_in = start_x_ff;
      start_y_in = start_y_ff;
      if (wr_beat) begin
         unique case (paddr[2])
            REG_START_X: start_x_in = pwdata[5:0];
            REG_START_Y: start_y_in = pwdata[5:0];
            default:     start_x_in = start_x_ff;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         start_x_ff <= 6'd1;
         start_y_ff <= 6'd1;
      end else begin
         start_x_ff <= start_x_in;
         start_y_ff <= start_y_in;
      end
   end

   always_comb begin
      unique case (paddr[2])
         REG_START_X: prdata = {26'd0, start_x_ff};
         REG_START_Y: prdata = {26'd0, start_y_ff};
         default:     prdata = 32'd0;
      endcase
   end

   assign start_x = start_x_ff;
   assign start_y = start_y_ff;

endmodule

`default_nettype wire

FILE: rtl/rhwf_datapath.sv
// ----------------------------------------------------------------------------
// rhwf_datapath
// Grid memory (single port), runner position and heading, result register.
// ----------------------------------------------------------------------------
`default_nettype none

module rhwf_datapath
   import rhwf_pkg::*;
#(
   parameter int GRID_SIDE = 64
) (
   input  wire logic     clock,
   input  wire logic     reset,
   input  wire mode_type req_mode,
   input  wire logic [5:0] req_cell_x,
   input  wire logic [5:0] req_cell_y,
   input  wire code_type req_cell_code,
   input  wire logic [5:0] start_x,
   input  wire logic [5:0] start_y,
   input  wire cmd_type  cmd,
   output sts_type       sts,
   output logic [5:0]    rsp_pos_x,
   output logic [5:0]    rsp_pos_y,
   output dir_type       rsp_heading,
   output logic          rsp_at_end,
   output logic          rsp_moved,
   output code_type      rsp_read_code
);

   localparam int CoordLimit = (GRID_SIDE < 64) ? GRID_SIDE : 64;
   localparam int Depth      = CoordLimit * CoordLimit;
   localparam int AddrWidth  = $clog2(Depth);

   // latched item
   mode_type   mode_ff;
   logic [5:0] cell_x_ff;
   logic [5:0] cell_y_ff;
   code_type   code_ff;

   // runner
   logic [5:0] rx_ff, rx_in;
   logic [5:0] ry_ff, ry_in;
   dir_type    dir_ff, dir_in;
   code_type   here_ff, here_in;
   code_type   shown_ff, shown_in;
   logic       moved_ff, moved_in;

   // grid
   code_type   grid_ff [Depth];
   code_type   mem_q_ff;
   logic       rd_off_ff;
   code_type   rd_code;

   logic [6:0]           nx, ny;
   logic [6:0]           acc_x, acc_y;
   logic                 acc_off;
   logic [AddrWidth-1:0] acc_addr;
   logic                 mem_we;
   code_type             mem_wdata;

   // neighbour in the commanded direction, 7 bits so that -1 and 64 fall off
   always_comb begin
      nx = {1'b0, rx_ff};
      ny = {1'b0, ry_ff};
      unique case (cmd.dir)
         DIR_NORTH: ny = {1'b0, ry_ff} + 7'h7f;
         DIR_EAST:  nx = {1'b0, rx_ff} + 7'd1;
         DIR_SOUTH: ny = {1'b0, ry_ff} + 7'd1;
         DIR_WEST:  nx = {1'b0, rx_ff} + 7'h7f;
         default:   nx = {1'b0, rx_ff};
      endcase
   end

   always_comb begin
      unique case (cmd.sel)
         SEL_RUNNER: begin
            acc_x = {1'b0, rx_ff};
            acc_y = {1'b0, ry_ff};
         end
         SEL_CELL: begin
            acc_x = {1'b0, cell_x_ff};
            acc_y = {1'b0, cell_y_ff};
         end
         SEL_NEIGH: begin
            acc_x = nx;
            acc_y = ny;
         end
         default: begin
            acc_x = {1'b0, rx_ff};
            acc_y = {1'b0, ry_ff};
         end
      endcase
   end

   assign acc_off  = (acc_x >= 7'(CoordLimit)) || (acc_y >= 7'(CoordLimit));
   assign acc_addr = AddrWidth'(acc_y[5:0]) * AddrWidth'(CoordLimit)
                   + AddrWidth'(acc_x[5:0]);

   assign rd_code   = rd_off_ff ? CODE_WALL : mem_q_ff;
   assign mem_we    = (cmd.wr_cell || cmd.wr_crumb) && !acc_off;
   assign mem_wdata = cmd.wr_cell ? code_ff : next_crumb(rd_code);

   always_ff @(posedge clock) begin
      if (mem_we) begin
         grid_ff[acc_addr] <= mem_wdata;
      end
      if (cmd.rd_en) begin
         mem_q_ff  <= grid_ff[acc_addr];
         rd_off_ff <= acc_off;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.load_req) begin
         mode_ff   <= req_mode;
         cell_x_ff <= req_cell_x;
         cell_y_ff <= req_cell_y;
         code_ff   <= req_cell_code;
      end
   end

   always_comb begin
      rx_in    = rx_ff;
      ry_in    = ry_ff;
      dir_in   = dir_ff;
      here_in  = here_ff;
      shown_in = shown_ff;
      moved_in = moved_ff;
      if (cmd.load_req) begin
         moved_in = 1'b0;
      end
      if (cmd.restart) begin
         rx_in  = start_x;
         ry_in  = start_y;
         dir_in = DIR_SOUTH;
      end
      if (cmd.cap_here) begin
         here_in = rd_code;
      end
      if (cmd.cap_shown) begin
         shown_in = rd_code;
      end
      if (cmd.set_dir) begin
         dir_in = cmd.dir;
      end
      if (cmd.wr_crumb) begin
         rx_in    = nx[5:0];
         ry_in    = ny[5:0];
         dir_in   = cmd.dir;
         here_in  = next_crumb(rd_code);
         moved_in = 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rx_ff  <= 6'd1;
         ry_ff  <= 6'd1;
         dir_ff <= DIR_SOUTH;
      end else begin
         rx_ff  <= rx_in;
         ry_ff  <= ry_in;
         dir_ff <= dir_in;
      end
      here_ff  <= here_in;
      shown_ff <= shown_in;
      moved_ff <= moved_in;
   end

   // result register
   always_ff @(posedge clock) begin
      if (cmd.out_load) begin
         rsp_pos_x     <= rx_ff;
         rsp_pos_y     <= ry_ff;
         rsp_heading   <= dir_ff;
         rsp_at_end    <= (here_ff == CODE_END);
         rsp_moved     <= moved_ff;
         rsp_read_code <= (mode_ff == MODE_READ) ? shown_ff : here_ff;
      end
   end

   assign sts.code_wall = (rd_code == CODE_WALL);
   assign sts.code_end  = (rd_code == CODE_END);
   assign sts.heading   = dir_ff;
   assign sts.mode      = mode_ff;

endmodule

`default_nettype wire

FILE: rtl/rhwf_ctrl.sv
// ----------------------------------------------------------------------------
// rhwf_ctrl
// Sequencer: orders grid accesses per mode and owns both handshakes.
// ----------------------------------------------------------------------------
`default_nettype none

`include "right_hand_wall_follower_core_macros.svh"

module rhwf_ctrl
   import rhwf_pkg::*;
(
   input  wire logic     clock,
   input  wire logic     reset,
   input  wire logic     req_valid,
   input  wire mode_type req_mode,
   output logic          req_stall,
   output logic          rsp_valid,
   input  wire logic     rsp_stall,
   input  wire sts_type  sts,
   output cmd_type       cmd
);

   localparam logic [3:0] ST_IDLE      = 4'd0;
   localparam logic [3:0] ST_WR_CELL   = 4'd1;
   localparam logic [3:0] ST_RESTART   = 4'd2;
   localparam logic [3:0] ST_RD_CELL   = 4'd3;
   localparam logic [3:0] ST_RD_HERE   = 4'd4;
   localparam logic [3:0] ST_FIN_HERE  = 4'd5;
   localparam logic [3:0] ST_STEP_HERE = 4'd6;
   localparam logic [3:0] ST_LOOK_R    = 4'd7;
   localparam logic [3:0] ST_LOOK_F    = 4'd8;
   localparam logic [3:0] ST_LOOK_L    = 4'd9;
   localparam logic [3:0] ST_LOOK_B    = 4'd10;
   localparam logic [3:0] ST_OUT       = 4'd11;

   logic [3:0] state_ff, state_in;
   logic       rsp_valid_ff, rsp_valid_in;
   logic       req_beat;
   dir_type    dir_right, dir_left, dir_back;

   assign req_stall = (state_ff != ST_IDLE);
   assign req_beat  = req_valid && !req_stall;
   assign rsp_valid = rsp_valid_ff;

   assign dir_right = sts.heading + 2'd1;
   assign dir_left  = sts.heading + 2'd3;
   assign dir_back  = sts.heading + 2'd2;

   always_comb begin
      state_in = state_ff;
      cmd      = '0;
      cmd.sel  = SEL_RUNNER;
      cmd.dir  = sts.heading;
      unique case (state_ff)
         ST_IDLE: begin
            if (req_beat) begin
               cmd.load_req = 1'b1;
               unique case (req_mode)
                  MODE_WRITE:   state_in = ST_WR_CELL;
                  MODE_STEP:    state_in = ST_RD_HERE;
                  MODE_READ:    state_in = ST_RD_CELL;
                  MODE_RESTART: state_in = ST_RESTART;
                  default:      state_in = ST_IDLE;
               endcase
            end
         end
         ST_WR_CELL: begin
            cmd.sel     = SEL_CELL;
            cmd.wr_cell = 1'b1;
            state_in    = ST_RD_HERE;
         end
         ST_RESTART: begin
            cmd.restart = 1'b1;
            state_in    = ST_RD_HERE;
         end
         ST_RD_CELL: begin
            cmd.sel   = SEL_CELL;
            cmd.rd_en = 1'b1;
            state_in  = ST_RD_HERE;
         end
         ST_RD_HERE: begin
            cmd.rd_en     = 1'b1;
            cmd.cap_shown = (sts.mode == MODE_READ);
            state_in      = (sts.mode == MODE_STEP) ? ST_STEP_HERE : ST_FIN_HERE;
         end
         ST_FIN_HERE: begin
            cmd.cap_here = 1'b1;
            state_in     = ST_OUT;
         end
         ST_STEP_HERE: begin
            cmd.cap_here = 1'b1;
            if (sts.code_end) begin
               state_in = ST_OUT;
            end else begin
               cmd.rd_en = 1'b1;
               cmd.sel   = SEL_NEIGH;
               cmd.dir   = dir_right;
               state_in  = ST_LOOK_R;
            end
         end
         ST_LOOK_R: begin
            cmd.sel = SEL_NEIGH;
            cmd.dir = dir_right;
            if (!sts.code_wall) begin
               cmd.wr_crumb = 1'b1;
               state_in     = ST_OUT;
            end else begin
               cmd.rd_en = 1'b1;
               cmd.dir   = sts.heading;
               state_in  = ST_LOOK_F;
            end
         end
         ST_LOOK_F: begin
            cmd.sel = SEL_NEIGH;
            cmd.dir = sts.heading;
            if (!sts.code_wall) begin
               cmd.wr_crumb = 1'b1;
               state_in     = ST_OUT;
            end else begin
               cmd.rd_en = 1'b1;
               cmd.dir   = dir_left;
               state_in  = ST_LOOK_L;
            end
         end
         ST_LOOK_L: begin
            cmd.sel = SEL_NEIGH;
            cmd.dir = dir_left;
            if (!sts.code_wall) begin
               cmd.wr_crumb = 1'b1;
               state_in     = ST_OUT;
            end else begin
               cmd.rd_en = 1'b1;
               cmd.dir   = dir_back;
               state_in  = ST_LOOK_B;
            end
         end
         ST_LOOK_B: begin
            // boxed in on three sides: turn back, move only if the way is open
            cmd.sel = SEL_NEIGH;
            cmd.dir = dir_back;
            if (!sts.code_wall) begin
               cmd.wr_crumb = 1'b1;
            end else begin
               cmd.set_dir = 1'b1;
            end
            state_in = ST_OUT;
         end
         ST_OUT: begin
            if (!rsp_valid_ff || !rsp_stall) begin
               cmd.out_load = 1'b1;
               state_in     = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   assign rsp_valid_in = cmd.out_load || (rsp_valid_ff && rsp_stall);

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // single grid port: never a read and a write together
   `RHWF_CHECK(a_one_port, cmd.rd_en, !(cmd.wr_cell || cmd.wr_crumb), "grid port clash")
   // a breadcrumb is only laid on a cell that is not wall
   `RHWF_CHECK(a_crumb_open, cmd.wr_crumb, !sts.code_wall, "crumb on wall")
   // a pending result that is stalled must not be overwritten
   `RHWF_CHECK(a_no_overrun, rsp_valid_ff && rsp_stall, !cmd.out_load, "result overrun")
   // an accepted beat always starts work
   `RHWF_CHECK_NEXT(a_busy_after_beat, req_beat, state_ff != ST_IDLE, "beat dropped")

endmodule

`default_nettype wire

FILE: rtl/right_hand_wall_follower_core.sv
// ----------------------------------------------------------------------------
// right_hand_wall_follower_core
// Maze grid with a right-hand-rule runner; write, read, step and restart.
// ----------------------------------------------------------------------------
// Use: a request beat on req_* (valid/stall) carries a mode and a cell. Mode
// write stores a cell code, read returns one, restart puts the runner at the
// start registers facing south, step makes at most one right-hand-rule move. Each
// request beat gives exactly one response beat on rsp_* with the runner's
// position, heading, end flag, move flag and a cell code.
// A step that starts on the end cell loads its result without looking at a
// neighbour; any other step reads one neighbour after another until it finds
// one open or has looked back. One request is in flight at a time and the
// next is taken the cycle after the result loads. The single-port grid memory
// is read once per neighbour looked at.
// A finished result sits in the response register; while rsp_stall holds
// it there, the next request is still taken and worked on, and only its
// result waits for the register to free.
// Reset: start registers 1,1, runner at 1,1 facing south, no response
// pending. The grid is not cleared; cells must be written before use.
// Start registers are written over the APB-style port (addresses 0 and 4).
// ----------------------------------------------------------------------------
`default_nettype none

module right_hand_wall_follower_core
   import rhwf_pkg::*;
#(
   parameter int GRID_SIDE = 64
) (
   input  wire logic        clock,
   input  wire logic        reset,
   // request channel
   input  wire logic        req_valid,
   output logic             req_stall,
   input  wire logic [1:0]  req_mode,
   input  wire logic [5:0]  req_cell_x,
   input  wire logic [5:0]  req_cell_y,
   input  wire logic [2:0]  req_cell_code,
   // response channel
   output logic             rsp_valid,
   input  wire logic        rsp_stall,
   output logic [5:0]       rsp_pos_x,
   output logic [5:0]       rsp_pos_y,
   output logic [1:0]       rsp_heading,
   output logic             rsp_at_end,
   output logic             rsp_moved,
   output logic [2:0]       rsp_read_code,
   // configuration port
   input  wire logic        psel,
   input  wire logic        penable,
   input  wire logic        pwrite,
   input  wire logic [2:0]  paddr,
   input  wire logic [31:0] pwdata,
   output logic [31:0]      prdata,
   output logic             pready
);

   cmd_type    cmd;
   sts_type    sts;
   logic [5:0] start_x;
   logic [5:0] start_y;

   // start position registers
   rhwf_csr u_csr (
      .clock   (clock),
      .reset   (reset),
      .psel    (psel),
      .penable (penable),
      .pwrite  (pwrite),
      .paddr   (paddr),
      .pwdata  (pwdata),
      .prdata  (prdata),
      .pready  (pready),
      .start_x (start_x),
      .start_y (start_y)
   );

   // sequencer: at most one grid access per cycle, steps look right, forward,
   // left, back in turn and stop at the first open cell
   rhwf_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_mode  (req_mode),
      .req_stall (req_stall),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .sts       (sts),
      .cmd       (cmd)
   );

   // grid, runner state and response register
   rhwf_datapath #(
      .GRID_SIDE (GRID_SIDE)
   ) u_datapath (
      .clock         (clock),
      .reset         (reset),
      .req_mode      (req_mode),
      .req_cell_x    (req_cell_x),
      .req_cell_y    (req_cell_y),
      .req_cell_code (req_cell_code),
      .start_x       (start_x),
      .start_y       (start_y),
      .cmd           (cmd),
      .sts           (sts),
      .rsp_pos_x     (rsp_pos_x),
      .rsp_pos_y     (rsp_pos_y),
      .rsp_heading   (rsp_heading),
      .rsp_at_end    (rsp_at_end),
      .rsp_moved     (rsp_moved),
      .rsp_read_code (rsp_read_code)
   );

endmodule

`default_nettype wire
